/* hdl/descriptor_slot_table_assert.svh */
// Assertion macros used by the checker file.
`ifndef DESCRIPTOR_SLOT_TABLE_ASSERT_SVH
`define DESCRIPTOR_SLOT_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define DST_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("assertion failed");
// Next-cycle implication.
`define DST_ASSERT_NXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("assertion failed");
`endif

/* hdl/dst_pkg.sv */
// ----------------------------------------------------------------------------
// dst_pkg
// Types and constants of the descriptor slot table.
// ----------------------------------------------------------------------------
package dst_pkg;
	localparam int TABLE_SLOTS = 64;
	localparam int HANDLE_BITS = 32;
	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int MAX_RES = 64;

	typedef enum logic [3:0] {
		ACT_LOOKUP = 4'd0, ACT_INST_LOW = 4'd1, ACT_INST_AT = 4'd2, ACT_TAKE = 4'd3,
		ACT_RD_FLAGS = 4'd4, ACT_WR_FLAGS = 4'd5, ACT_DUP = 4'd6, ACT_DUP_ONTO = 4'd7,
		ACT_PAIR = 4'd8, ACT_EXEC_SWEEP = 4'd9, ACT_CLEAR = 4'd10, ACT_FORK_LIST = 4'd11
	} action_t;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_BAD = 3'd1;
	localparam logic [2:0] ST_INVAL = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BUSY = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_SCAN, S_EXEC, S_OUT
	} state_t;

	// scanner request / response
	typedef struct packed {
		logic       start;
		logic [6:0] from;
		logic [6:0] limit;
	} scan_req_t;

	typedef struct packed {
		logic             done;
		logic             found;
		logic [IDX_W-1:0] idx;
	} scan_rsp_t;
endpackage

/* hdl/dst_ram.sv */
// ----------------------------------------------------------------------------
// dst_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module dst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

/* hdl/dst_scan.sv */
// ----------------------------------------------------------------------------
// dst_scan
// Lowest-free search over the live bitmap, one slot per cycle.
// ----------------------------------------------------------------------------
module dst_scan import dst_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  scan_req_t              req,
	input  logic [TABLE_SLOTS-1:0] live,
	output scan_rsp_t              rsp
);
	logic       busy_q;
	logic [6:0] pos_q;
	logic [6:0] lim_q;
	logic       hit;
	logic       at_end;

	assign at_end = pos_q >= lim_q;
	assign hit = !at_end && !live[pos_q[IDX_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			lim_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			pos_q  <= req.from;
			lim_q  <= req.limit;
		end else if (busy_q) begin
			if (hit || at_end) begin
				busy_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 7'd1;
			end
		end
	end

	assign rsp.done  = busy_q && (hit || at_end);
	assign rsp.found = hit;
	assign rsp.idx   = pos_q[IDX_W-1:0];
endmodule

/* hdl/descriptor_slot_table.sv */
// ----------------------------------------------------------------------------
// descriptor_slot_table
// Slot table with lowest-free allocation, sweeps and fork listing.
// ----------------------------------------------------------------------------
// channel  dir  handshake           content
// s_axis   in   tvalid/tready       action and operands
// m_axis   out  tvalid/tready/tlast one result per transfer
// cfg      in   cfg_we              slot_limit
// Simple actions pass through a RAM read step, a decide-and-write-back step and
// a return to idle per input transfer; the result is registered in the decide
// step. Duplicate onto adds a target read and wait step. Searches step one slot
// per cycle through the shared scanner (two searches for a pair); sweeps and
// listings walk every slot through the RAM port (read, wait, decide) plus stalls.
// Reset frees every slot and sets the limit to 64; the RAM needs no clearing.
// m_axis stalls hold the sequencer; s_axis is ready only in idle.
// ----------------------------------------------------------------------------
module descriptor_slot_table import dst_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: action[3:0] slot_index[9:4] target_index[15:10] min_index[21:16]
	// handle_in[53:22] second_handle_in[85:54] flags_in[87:86]
	// second_flags_in[89:88] reject_same[90], zero fill to 96
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: status[2:0] index_out[8:3] handle_out[40:9] handle_valid[41]
	// flags_out[43:42], zero fill to 48
	output logic [47:0]  m_axis_tdata,
	output logic         m_axis_tlast,
	input  logic         cfg_we,
	input  logic [6:0]   cfg_wdata
);
	state_t state_q, state_d;
	logic [6:0] limit_q;
	logic [TABLE_SLOTS-1:0] live_q;

	logic [3:0]  act_q;
	logic [5:0]  s_q, t_q, mn_q;
	logic [HANDLE_BITS-1:0] h1_q, h2_q;
	logic [1:0]  f1_q, f2_q;
	logic        rej_q;
	logic [1:0]  phase_q;
	logic [6:0]  walk_q;
	logic [6:0]  nres_q;
	logic [IDX_W-1:0] first_q;
	logic [HANDLE_BITS-1:0] src_h_q;

	logic [2:0]  o_st_q;
	logic [5:0]  o_idx_q;
	logic [31:0] o_h_q;
	logic        o_hv_q;
	logic [1:0]  o_fl_q;
	logic        o_last_q;
	logic        o_valid_q;

	logic [6:0] eff_lim;
	assign eff_lim = (limit_q > 7'(TABLE_SLOTS)) ? 7'(TABLE_SLOTS) : limit_q;

	// RAM port
	logic ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [HANDLE_BITS+1:0] ram_wdata, ram_rdata;
	logic [HANDLE_BITS-1:0] rd_h;
	logic [1:0] rd_f;
	assign rd_h = ram_rdata[HANDLE_BITS+1:2];
	assign rd_f = ram_rdata[1:0];

	dst_ram #(.WIDTH(HANDLE_BITS + 2), .DEPTH(TABLE_SLOTS)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	scan_req_t sreq;
	scan_rsp_t srsp;
	dst_scan u_scan (.clk(clk), .arst_n(arst_n), .req(sreq), .live(live_q), .rsp(srsp));

	logic s_ok, t_ok, mn_ok;
	assign s_ok  = 7'(s_q) < 7'(TABLE_SLOTS);
	assign t_ok  = 7'(t_q) < 7'(TABLE_SLOTS);
	assign mn_ok = 7'(mn_q) < 7'(TABLE_SLOTS);
	logic [IDX_W-1:0] si, ti, wi;
	assign si = s_q[IDX_W-1:0];
	assign ti = t_q[IDX_W-1:0];
	assign wi = walk_q[IDX_W-1:0];
	logic [HANDLE_BITS-1:0] h1m, h2m;
	assign h1m = h1_q;
	assign h2m = h2_q;

	logic out_free;
	assign out_free = !o_valid_q || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// control events decided combinationally, applied in the register block
	logic       emit;
	logic [2:0] e_st;
	logic [5:0] e_idx;
	logic [31:0] e_h;
	logic       e_hv;
	logic [1:0] e_fl;
	logic       e_last;
	logic       set_live, clr_live, clr_all;
	logic [IDX_W-1:0] live_idx;
	logic       go_idle, go_exec, go_scan, go_walk;
	logic [1:0] phase_d;
	logic [6:0] walk_d, nres_d;
	logic       save_first, save_src;

	always_comb begin
		state_d = state_q;
		if (go_idle) state_d = S_IDLE;
		else if (go_scan) state_d = S_SCAN;
		else if (go_exec) state_d = S_EXEC;
		else if (go_walk) state_d = S_OUT;
		else begin
			case (state_q)
				S_IDLE: if (s_axis_tvalid) state_d = S_READ;
				S_READ: state_d = S_EXEC;
				default: state_d = state_q;
			endcase
		end
	end

	always_comb begin
		emit = 1'b0; e_st = ST_OK; e_idx = '0; e_h = '0; e_hv = 1'b0; e_fl = '0; e_last = 1'b1;
		set_live = 1'b0; clr_live = 1'b0; clr_all = 1'b0; live_idx = si;
		go_idle = 1'b0; go_exec = 1'b0; go_scan = 1'b0; go_walk = 1'b0;
		phase_d = phase_q; walk_d = walk_q; nres_d = nres_q;
		save_first = 1'b0; save_src = 1'b0;
		ram_we = 1'b0; ram_addr = si; ram_wdata = '0;
		sreq.start = 1'b0; sreq.from = 7'(mn_q); sreq.limit = eff_lim;
		// keep the read address on the slot in use while the output stalls
		if (act_q == ACT_EXEC_SWEEP || act_q == ACT_FORK_LIST) ram_addr = wi;
		else if (act_q == ACT_DUP_ONTO && phase_q != 2'd0) ram_addr = ti;
		case (state_q)
			S_READ: begin
				ram_addr = si;
				phase_d = 2'd0;
				walk_d = '0;
				nres_d = '0;
			end
			S_EXEC: if (out_free) begin
				case (act_q)
					ACT_LOOKUP, ACT_RD_FLAGS: begin
						emit = 1'b1; go_idle = 1'b1;
						if (!s_ok || !live_q[si]) e_st = ST_BAD;
						else begin
							e_idx = s_q; e_fl = rd_f;
							if (act_q == ACT_LOOKUP) begin
								e_h = 32'(rd_h); e_hv = 1'b1;
							end
						end
					end
					ACT_TAKE: begin
						emit = 1'b1; go_idle = 1'b1;
						if (!s_ok || !live_q[si]) e_st = ST_BAD;
						else begin
							e_idx = s_q; e_fl = rd_f; e_h = 32'(rd_h); e_hv = 1'b1;
							clr_live = 1'b1;
						end
					end
					ACT_WR_FLAGS: begin
						emit = 1'b1; go_idle = 1'b1;
						if (!s_ok || !live_q[si]) e_st = ST_BAD;
						else begin
							e_idx = s_q; ram_we = 1'b1; ram_wdata = {rd_h, f1_q};
						end
					end
					ACT_INST_AT: begin
						emit = 1'b1; go_idle = 1'b1;
						if (h1m == '0 || !s_ok) e_st = ST_INVAL;
						else if (7'(s_q) >= eff_lim) e_st = ST_FULL;
						else if (live_q[si]) e_st = ST_BUSY;
						else begin
							e_idx = s_q; ram_we = 1'b1; ram_wdata = {h1m, 2'b00};
							set_live = 1'b1;
						end
					end
					ACT_INST_LOW, ACT_DUP: begin
						if (phase_q == 2'd0) begin
							if (act_q == ACT_INST_LOW && (h1m == '0 || !mn_ok)) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_INVAL;
							end else if (act_q == ACT_DUP && !s_ok) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_BAD;
							end else if (act_q == ACT_DUP && !mn_ok) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_INVAL;
							end else if (act_q == ACT_DUP && !live_q[si]) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_BAD;
							end else begin
								save_src = 1'b1; sreq.start = 1'b1; go_scan = 1'b1;
								phase_d = 2'd1;
							end
						end else begin
							emit = 1'b1; go_idle = 1'b1;
							if (!srsp.found) e_st = ST_FULL;
							else begin
								e_idx = 6'(srsp.idx); live_idx = srsp.idx; set_live = 1'b1;
								ram_we = 1'b1; ram_addr = srsp.idx;
								ram_wdata = {(act_q == ACT_DUP) ? src_h_q : h1m, f1_q};
							end
						end
					end
					ACT_DUP_ONTO: begin
						if (phase_q == 2'd0) begin
							if (!s_ok || !t_ok || !live_q[si]) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_BAD;
							end else if (s_q == t_q) begin
								emit = 1'b1; go_idle = 1'b1;
								if (rej_q) e_st = ST_INVAL; else e_idx = t_q;
							end else if (7'(t_q) >= eff_lim) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_BAD;
							end else begin
								save_src = 1'b1; ram_addr = ti; phase_d = 2'd1;
							end
						end else if (phase_q == 2'd1) begin
							ram_addr = ti; phase_d = 2'd2;
						end else begin
							emit = 1'b1; go_idle = 1'b1; e_idx = t_q;
							if (live_q[ti]) begin
								e_h = 32'(rd_h); e_hv = 1'b1;
							end
							ram_we = 1'b1; ram_addr = ti; ram_wdata = {src_h_q, f1_q};
							live_idx = ti; set_live = 1'b1;
						end
					end
					ACT_PAIR: begin
						if (phase_q == 2'd0) begin
							if (h1m == '0 || h2m == '0) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_INVAL;
							end else begin
								sreq.start = 1'b1; sreq.from = '0; go_scan = 1'b1;
								phase_d = 2'd1;
							end
						end else if (phase_q == 2'd1) begin
							if (!srsp.found) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_FULL;
							end else begin
								save_first = 1'b1; sreq.start = 1'b1;
								sreq.from = 7'(srsp.idx) + 7'd1; go_scan = 1'b1;
								phase_d = 2'd2;
							end
						end else if (phase_q == 2'd2) begin
							if (!srsp.found) begin
								emit = 1'b1; go_idle = 1'b1; e_st = ST_FULL;
							end else begin
								emit = 1'b1; e_last = 1'b0; e_idx = 6'(first_q);
								live_idx = first_q; set_live = 1'b1;
								ram_we = 1'b1; ram_addr = first_q; ram_wdata = {h1m, f1_q};
								save_first = 1'b1; phase_d = 2'd3;
							end
						end else begin
							emit = 1'b1; go_idle = 1'b1; e_idx = 6'(first_q);
							live_idx = first_q; set_live = 1'b1;
							ram_we = 1'b1; ram_addr = first_q; ram_wdata = {h2m, f2_q};
						end
					end
					ACT_CLEAR: begin
						emit = 1'b1; go_idle = 1'b1; clr_all = 1'b1;
					end
					ACT_EXEC_SWEEP, ACT_FORK_LIST: begin
						// walk: phase 0 issue read, phase 1 wait, phase 2 decide
						ram_addr = wi;
						if (walk_q >= 7'(TABLE_SLOTS)) begin
							if (nres_q == '0) begin
								emit = 1'b1; go_idle = 1'b1;
							end else begin
								go_walk = 1'b1;
							end
						end else if (phase_q != 2'd2) begin
							phase_d = phase_q + 2'd1;
						end else begin
							phase_d = 2'd0; walk_d = walk_q + 7'd1;
							if (live_q[wi] && ((act_q == ACT_EXEC_SWEEP) ? rd_f[0] : !rd_f[1]))
							begin
								if (act_q == ACT_EXEC_SWEEP) begin
									live_idx = wi; clr_live = 1'b1;
								end
								if (nres_q < 7'(MAX_RES)) begin
									nres_d = nres_q + 7'd1;
									emit = 1'b1; e_last = 1'b0; e_idx = 6'(wi);
									e_h = 32'(rd_h); e_hv = 1'b1; e_fl = rd_f;
								end
							end
						end
					end
					default: begin
						emit = 1'b1; go_idle = 1'b1; e_st = ST_INVAL;
					end
				endcase
			end
			S_SCAN: begin
				if (srsp.done) go_exec = 1'b1;
			end
			default: ;
		endcase
	end

	// listing results are delayed by one slot so the final one can carry last
	logic        pend_q;
	logic [43:0] pend_d_q;
	logic        fin;
	logic        stage;
	assign fin = (state_q == S_OUT) && out_free;
	assign stage = emit && !e_last && (act_q == ACT_EXEC_SWEEP || act_q == ACT_FORK_LIST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			limit_q   <= 7'd64;
			live_q    <= '0;
			o_valid_q <= 1'b0;
			pend_q    <= 1'b0;
			phase_q   <= '0;
			walk_q    <= '0;
			nres_q    <= '0;
		end else begin
			if (cfg_we) limit_q <= cfg_wdata;
			state_q <= fin ? S_IDLE : state_d;
			phase_q <= phase_d;
			walk_q  <= walk_d;
			nres_q  <= nres_d;
			if (clr_all) live_q <= '0;
			else if (set_live) live_q[live_idx] <= 1'b1;
			else if (clr_live) live_q[live_idx] <= 1'b0;
			// a staged listing entry flushes the previous one
			if ((emit && !(stage && !pend_q)) || fin) o_valid_q <= 1'b1;
			else if (m_axis_tready) o_valid_q <= 1'b0;
			if (stage) pend_q <= 1'b1;
			else if (fin) pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			act_q <= s_axis_tdata[3:0];
			s_q   <= s_axis_tdata[9:4];
			t_q   <= s_axis_tdata[15:10];
			mn_q  <= s_axis_tdata[21:16];
			h1_q  <= s_axis_tdata[53:22];
			h2_q  <= s_axis_tdata[85:54];
			f1_q  <= s_axis_tdata[87:86];
			f2_q  <= s_axis_tdata[89:88];
			rej_q <= s_axis_tdata[90];
		end
		if (save_src) src_h_q <= rd_h;
		if (save_first) first_q <= srsp.idx;
		if (stage) begin
			if (pend_q) begin
				{o_st_q, o_idx_q, o_h_q, o_hv_q, o_fl_q} <= pend_d_q;
				o_last_q <= 1'b0;
			end
			pend_d_q <= {e_st, e_idx, e_h, e_hv, e_fl};
		end else if (emit) begin
			{o_st_q, o_idx_q, o_h_q, o_hv_q, o_fl_q} <= {e_st, e_idx, e_h, e_hv, e_fl};
			o_last_q <= e_last;
		end else if (fin) begin
			{o_st_q, o_idx_q, o_h_q, o_hv_q, o_fl_q} <= pend_d_q;
			o_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {4'b0, o_fl_q, o_hv_q, o_h_q, o_idx_q, o_st_q};
endmodule

/* hdl/dst_checker.sv */
// ----------------------------------------------------------------------------
// dst_checker
// Port-level checks of the descriptor slot table.
// ----------------------------------------------------------------------------
`include "descriptor_slot_table_assert.svh"
module dst_checker import dst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tlast
);
	`DST_ASSERT_NXT(a_no_back2back, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`DST_ASSERT_IMP(a_err_alone, clk, arst_n, m_axis_tvalid && m_axis_tdata[2:0] != ST_OK,
		m_axis_tlast && m_axis_tdata[41:3] == '0)
	`DST_ASSERT_NXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata))
	`DST_ASSERT_IMP(a_status_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[2:0] <= ST_BUSY)
endmodule

bind descriptor_slot_table dst_checker u_dst_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
);
